[hdl/rse_pkg.sv]
package rse_pkg;

   localparam int OUT_WORD_BITS  = 16;
   localparam int STATE_BITS     = 32;
   localparam int LOWER_BOUND    = 65536;
   localparam int LB_BITS        = 16;
   localparam int SCALE_BITS_DEF = 12;
   localparam int SYMBOL_BITS    = 8;
   localparam int FREQ_BITS      = 13;
   localparam int START_BITS     = 12;
   localparam int ENTRY_BITS     = FREQ_BITS + START_BITS;
   localparam int TABLE_DEPTH    = 256;
   localparam int OPCODE_BITS    = 2;

   localparam logic [OPCODE_BITS-1:0] OP_LOAD   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_ENCODE = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_FINISH = 2'd2;

   localparam logic [1:0] EMIT_LOW  = 2'd0;
   localparam logic [1:0] EMIT_HIGH = 2'd1;
   localparam logic [1:0] EMIT_ERR  = 2'd2;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [SYMBOL_BITS-1:0] symbol;
      logic [FREQ_BITS-1:0]   entry_freq;
      logic [START_BITS-1:0]  entry_start;
   } req_type;

   typedef struct packed {
      logic [OUT_WORD_BITS-1:0] out_word;
      logic                     final_word;
      logic                     zero_freq_error;
   } rsp_type;

   typedef struct packed {
      logic       latch_entry;
      logic       shift_out;
      logic       div_init;
      logic       div_step;
      logic       state_update;
      logic       state_reset;
      logic       emit;
      logic [1:0] emit_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic freq_zero;
      logic renorm_needed;
      logic div_last;
   } dp_status_type;

endpackage

[hdl/rse_ram.sv]
module rse_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rse_ctrl.sv]
module rse_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [1:0]                    req_opcode,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          ram_wr_en,
   output logic                          ram_rd_en,
   output rse_pkg::dp_cmd_type           cmd,
   input  rse_pkg::dp_status_type        status
);

   import rse_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_LOOKUP   = 3'd1;
   localparam logic [2:0] ST_CHECK    = 3'd2;
   localparam logic [2:0] ST_DIV_INIT = 3'd3;
   localparam logic [2:0] ST_DIV      = 3'd4;
   localparam logic [2:0] ST_UPDATE   = 3'd5;
   localparam logic [2:0] ST_FLUSH_LO = 3'd6;
   localparam logic [2:0] ST_FLUSH_HI = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // output register can take a new result when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ram_wr_en = accept && (req_opcode == OP_LOAD);
   assign ram_rd_en = accept && (req_opcode == OP_ENCODE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit_sel = EMIT_LOW;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_ENCODE) begin
               state_in = ST_LOOKUP;
            end else if (accept && req_opcode == OP_FINISH) begin
               state_in = ST_FLUSH_LO;
            end
         end
         ST_LOOKUP: begin
            cmd.latch_entry = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.freq_zero) begin
               if (out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_ERR;
                  state_in     = ST_IDLE;
               end
            end else if (status.renorm_needed) begin
               if (out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_LOW;
                  cmd.shift_out = 1'b1;
                  state_in      = ST_DIV_INIT;
               end
            end else begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.state_update = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FLUSH_LO: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_LOW;
               state_in     = ST_FLUSH_HI;
            end
         end
         ST_FLUSH_HI: begin
            if (out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_sel    = EMIT_HIGH;
               cmd.state_reset = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/rse_datapath.sv]
module rse_datapath #(
   parameter int SCALE_BITS = rse_pkg::SCALE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rse_pkg::dp_cmd_type                   cmd,
   output rse_pkg::dp_status_type                status,
   input  logic [rse_pkg::ENTRY_BITS-1:0]        entry,
   output rse_pkg::rsp_type                      rsp_data
);

   import rse_pkg::*;

   // quotient width: state stays below freq << QUO_BITS after renormalization
   localparam int QUO_BITS = LB_BITS - SCALE_BITS + OUT_WORD_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS);

   logic [STATE_BITS-1:0] x_ff, x_in;
   logic [FREQ_BITS-1:0]  freq_ff;
   logic [START_BITS-1:0] start_ff;
   logic [FREQ_BITS-1:0]  rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [FREQ_BITS-1:0]  x_top;
   logic [FREQ_BITS:0]    trial;
   logic [FREQ_BITS:0]    diff;
   logic                  ge;

   assign x_top = {{(FREQ_BITS-SCALE_BITS){1'b0}}, x_ff[STATE_BITS-1:QUO_BITS]};

   assign status.freq_zero     = (freq_ff == '0);
   // x >= freq << QUO_BITS is the same as x >> QUO_BITS >= freq
   assign status.renorm_needed = (x_top >= freq_ff);
   assign status.div_last      = (cnt_ff == CNT_BITS'(QUO_BITS - 1));

   // restoring divider, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[QUO_BITS-1]};
   assign diff  = trial - {1'b0, freq_ff};
   assign ge    = (trial >= {1'b0, freq_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = x_top;
         quo_in = x_ff[QUO_BITS-1:0];
      end else if (cmd.div_step) begin
         rem_in = ge ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
         quo_in = {quo_ff[QUO_BITS-2:0], ge};
      end
   end

   always_comb begin
      x_in = x_ff;
      if (cmd.shift_out) begin
         x_in = {{OUT_WORD_BITS{1'b0}}, x_ff[STATE_BITS-1:OUT_WORD_BITS]};
      end else if (cmd.state_update) begin
         x_in = {quo_ff, {SCALE_BITS{1'b0}}} + STATE_BITS'(rem_ff)
              + STATE_BITS'(start_ff);
      end else if (cmd.state_reset) begin
         x_in = STATE_BITS'(LOWER_BOUND);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         case (cmd.emit_sel)
            EMIT_HIGH: begin
               rsp_in.out_word        = x_ff[STATE_BITS-1:OUT_WORD_BITS];
               rsp_in.final_word      = 1'b1;
               rsp_in.zero_freq_error = 1'b0;
            end
            EMIT_ERR: begin
               rsp_in.out_word        = '0;
               rsp_in.final_word      = 1'b0;
               rsp_in.zero_freq_error = 1'b1;
            end
            default: begin
               rsp_in.out_word        = x_ff[OUT_WORD_BITS-1:0];
               rsp_in.final_word      = 1'b0;
               rsp_in.zero_freq_error = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= STATE_BITS'(LOWER_BOUND);
      end else begin
         x_ff <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_entry) begin
         freq_ff  <= entry[FREQ_BITS-1:0];
         start_ff <= entry[ENTRY_BITS-1:FREQ_BITS];
      end
      if (cmd.div_init) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[hdl/rans_symbol_encoder.sv]
// rANS encoder over a byte alphabet with 16-bit renormalization. Load a
// symbol's frequency and start before encoding it; encode symbols in reverse
// order, then finish to flush the 32-bit state as two words, low half first.
// An encode computes 32 - SCALE_BITS quotient bits with the one-bit-per-cycle
// restoring divider; a symbol with zero frequency skips the divider and
// returns an error result. An item is taken only after the previous one is
// done; an output register holds one result, so work stalls only while it
// is full.
module rans_symbol_encoder #(
   parameter int SCALE_BITS = rse_pkg::SCALE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rse_pkg::rsp_type rsp_data
);

   import rse_pkg::*;

   dp_cmd_type             cmd;
   dp_status_type          status;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [ENTRY_BITS-1:0]  ram_rd_data;

   rse_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (req_data.symbol),
      .wr_data ({req_data.entry_start, req_data.entry_freq}),
      .rd_data (ram_rd_data)
   );

   rse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .ram_wr_en  (ram_wr_en),
      .ram_rd_en  (ram_rd_en),
      .cmd        (cmd),
      .status     (status)
   );

   rse_datapath #(
      .SCALE_BITS (SCALE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .entry    (ram_rd_data),
      .rsp_data (rsp_data)
   );

endmodule
